// ----- sv/spr_pkg.sv -----
// Shared types, codes and widths for the square-ring spiral scanner.
package spr_pkg;

  localparam int CW   = 14;  // centre and bound coordinates, signed
  localparam int RW   = 15;  // ring radius, unsigned
  localparam int SW   = 16;  // step along a side, unsigned
  localparam int DW   = 17;  // signed working width of the side datapath
  localparam int DIMW = 13;  // grid size registers
  localparam int OUTW = 12;  // emitted cell coordinates

  localparam int MAX_GRID_DEF = 4096;

  // Command codes on the opcode field
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RADIUS,
    ST_SIDE,
    ST_CLIP
  } scan_state_t;

  // Result of evaluating one ring side against the grid
  typedef struct packed {
    logic                 fixed_ok;  // fixed coordinate lies inside the grid
    logic                 horiz;     // top or bottom side: varying axis is the column
    logic                 up;        // varying coordinate rises along the side
    logic signed [DW-1:0] fixed;
    logic signed [DW-1:0] base;
    logic signed [DW-1:0] lo;        // first in-grid step, clamped to 0
    logic signed [DW-1:0] hi;        // last in-grid step, clamped to 2r
  } side_eval_t;

  // Decision for the current cursor step on an evaluated side
  typedef struct packed {
    logic            skip;    // nothing in-grid left on this side
    logic            last;    // emitted step ends the side
    logic [SW-1:0]   k_next;
    logic [OUTW-1:0] col;
    logic [OUTW-1:0] row;
  } pick_t;

endpackage

// ----- sv/spr_side_eval.sv -----
// Side evaluation: fixed coordinate, side origin and in-grid step window.
module spr_side_eval (
  input  logic signed [spr_pkg::CW-1:0]   center_col,
  input  logic signed [spr_pkg::CW-1:0]   center_row,
  input  logic        [spr_pkg::RW-1:0]   radius,
  input  spr_pkg::side_t                  side,
  input  logic        [spr_pkg::DIMW-1:0] width_eff,
  input  logic        [spr_pkg::DIMW-1:0] height_eff,
  output spr_pkg::side_eval_t             eval
);
  import spr_pkg::*;

  logic signed [DW-1:0] cc, cr, rs, two_r;
  logic signed [DW-1:0] fixed, base, flim, vlim_m1, lo_raw, hi_raw;
  logic                 up, horiz;

  assign cc    = DW'(center_col);
  assign cr    = DW'(center_row);
  assign rs    = signed'(DW'(radius));
  assign two_r = signed'({{(DW-RW-1){1'b0}}, radius, 1'b0});

  always_comb begin
    case (side)
      SIDE_TOP: begin
        fixed = cr - rs; flim = signed'(DW'(height_eff));
        base = cc - rs; vlim_m1 = signed'(DW'(width_eff)) - DW'(1);
        up = 1'b1; horiz = 1'b1;
      end
      SIDE_RIGHT: begin
        fixed = cc + rs; flim = signed'(DW'(width_eff));
        base = cr - rs; vlim_m1 = signed'(DW'(height_eff)) - DW'(1);
        up = 1'b1; horiz = 1'b0;
      end
      SIDE_BOTTOM: begin
        fixed = cr + rs; flim = signed'(DW'(height_eff));
        base = cc + rs; vlim_m1 = signed'(DW'(width_eff)) - DW'(1);
        up = 1'b0; horiz = 1'b1;
      end
      default: begin
        fixed = cc - rs; flim = signed'(DW'(width_eff));
        base = cr + rs; vlim_m1 = signed'(DW'(height_eff)) - DW'(1);
        up = 1'b0; horiz = 1'b0;
      end
    endcase
  end

  assign lo_raw = up ? -base : base - vlim_m1;
  assign hi_raw = up ? vlim_m1 - base : base;

  assign eval.fixed_ok = (fixed >= 0) && (fixed < flim);
  assign eval.horiz    = horiz;
  assign eval.up       = up;
  assign eval.fixed    = fixed;
  assign eval.base     = base;
  assign eval.lo       = (lo_raw < 0) ? '0 : lo_raw;
  assign eval.hi       = (hi_raw < two_r) ? hi_raw : two_r;

endmodule

// ----- sv/spr_pick.sv -----
// Step selection: skip clipped steps, form the cell and advance the cursor.
module spr_pick (
  input  spr_pkg::side_eval_t           eval,
  input  logic [spr_pkg::SW-1:0]        side_step,
  input  logic [spr_pkg::RW-1:0]        radius,
  output spr_pkg::pick_t                pick
);
  import spr_pkg::*;

  logic signed [DW-1:0] step_s, k, v, two_r;

  assign step_s = signed'(DW'(side_step));
  assign two_r  = signed'({{(DW-RW-1){1'b0}}, radius, 1'b0});
  assign k      = (step_s > eval.lo) ? step_s : eval.lo;
  assign v      = eval.up ? eval.base + k : eval.base - k;

  assign pick.skip   = k > eval.hi;
  assign pick.last   = k >= two_r;
  assign pick.k_next = SW'(k + DW'(1));
  assign pick.col    = eval.horiz ? v[OUTW-1:0] : eval.fixed[OUTW-1:0];
  assign pick.row    = eval.horiz ? eval.fixed[OUTW-1:0] : v[OUTW-1:0];

endmodule

// ----- sv/spiral_ring_scan_clipped_unit.sv -----
// Top level of the clipped square-ring spiral scanner.
//
// Use: drive opcode and the coordinate fields with start high; the command is
// taken at a clock edge where busy is low. Every command gives exactly one
// result beat: done is high for one cycle with cell_col, cell_row, cell_valid.
// A start command (opcode 0) latches the centre and visible bounds, works out
// the largest radius one bound distance per cycle, and answers with
// cell_valid low once the radius is known; busy stays high until then.
// A next command (opcode 1) walks the ring cursor: a side whose fixed row or
// column lies off the grid is passed over in ST_SIDE alone, a side whose
// in-grid stretch is already used up passes through ST_SIDE and ST_CLIP, and
// the side that yields the cell goes through ST_SIDE and then ST_CLIP, which
// registers the cell. The side evaluator and step picker are the unit reused
// for every side of the walk; a ring with no in-grid cell is crossed within
// the same command, and busy stays high until the result beat.
// With no scan loaded the answer is cell_valid low with zero coordinates,
// done rising at the accept edge itself and busy staying low; the fetch that
// runs past the last ring gives the same empty answer from ST_SIDE and
// unloads the scan.
// grid_width (index 0) and grid_height (index 1) are written through cfg_write
// by the user, only while idle (unenforced); reset sets both to 1, drops scan.
// The receiver cannot stall: each result beat lasts exactly one cycle.
module spiral_ring_scan_clipped_unit #(
  parameter int MAX_GRID = spr_pkg::MAX_GRID_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic signed [spr_pkg::CW-1:0]   center_col,
  input  logic signed [spr_pkg::CW-1:0]   center_row,
  input  logic signed [spr_pkg::CW-1:0]   visible_col_min,
  input  logic signed [spr_pkg::CW-1:0]   visible_col_max,
  input  logic signed [spr_pkg::CW-1:0]   visible_row_min,
  input  logic signed [spr_pkg::CW-1:0]   visible_row_max,
  output logic                            done,
  output logic [spr_pkg::OUTW-1:0]        cell_col,
  output logic [spr_pkg::OUTW-1:0]        cell_row,
  output logic                            cell_valid,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [spr_pkg::DIMW-1:0]        cfg_data
);
  import spr_pkg::*;

  // Grid size clamp; a limit beyond the register range never bites
  localparam logic [DIMW-1:0] MAX_DIM =
    (MAX_GRID >= (1 << DIMW)) ? {DIMW{1'b1}} : DIMW'(MAX_GRID);

  scan_state_t state, state_next;

  logic [DIMW-1:0]        grid_width, grid_height;
  logic [DIMW-1:0]        width_eff, height_eff;

  logic signed [CW-1:0]   scan_center_col, scan_center_col_next;
  logic signed [CW-1:0]   scan_center_row, scan_center_row_next;
  logic signed [CW-1:0]   bnd_col_min, bnd_col_max, bnd_row_min, bnd_row_max;
  logic [1:0]             rad_idx, rad_idx_next;
  logic [RW-1:0]          last_radius, last_radius_next;
  logic [RW-1:0]          ring_radius, ring_radius_next;
  side_t                  ring_side, ring_side_next;
  logic [SW-1:0]          side_step, side_step_next;
  logic                   scan_active, scan_active_next;

  side_eval_t             eval, eval_q, eval_q_next;
  pick_t                  pick;

  logic                   done_next, cell_valid_next;
  logic [OUTW-1:0]        cell_col_next, cell_row_next;

  logic                   accept;
  logic signed [DW-1:0]   rad_a, rad_b, rad_d;
  logic [RW-1:0]          rad_mag;
  side_t                  side_adv;
  logic [RW-1:0]          ring_adv;

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign width_eff  = (grid_width  > MAX_DIM) ? MAX_DIM : grid_width;
  assign height_eff = (grid_height > MAX_DIM) ? MAX_DIM : grid_height;

  // Next side of the ring, rolling over into the next ring after the left side
  assign side_adv = side_t'(ring_side + 2'd1);
  assign ring_adv = (ring_side == SIDE_LEFT) ? ring_radius + RW'(1) : ring_radius;

  // Bound distance for the largest radius, one pair per cycle
  always_comb begin
    case (rad_idx)
      2'd0:    begin rad_a = DW'(scan_center_col); rad_b = DW'(bnd_col_min); end
      2'd1:    begin rad_a = DW'(bnd_col_max);     rad_b = DW'(scan_center_col); end
      2'd2:    begin rad_a = DW'(scan_center_row); rad_b = DW'(bnd_row_min); end
      default: begin rad_a = DW'(bnd_row_max);     rad_b = DW'(scan_center_row); end
    endcase
  end
  assign rad_d   = rad_a - rad_b;
  assign rad_mag = (rad_d < 0) ? RW'(-rad_d) : RW'(rad_d);

  spr_side_eval u_side_eval (
    .center_col (scan_center_col),
    .center_row (scan_center_row),
    .radius     (ring_radius),
    .side       (ring_side),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .eval       (eval)
  );

  spr_pick u_pick (
    .eval      (eval_q),
    .side_step (side_step),
    .radius    (ring_radius),
    .pick      (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_active <= 1'b0;
      done        <= 1'b0;
      cell_valid  <= 1'b0;
      ring_radius <= '0;
      ring_side   <= SIDE_TOP;
      side_step   <= '0;
      last_radius <= '0;
    end else begin
      state       <= state_next;
      scan_active <= scan_active_next;
      done        <= done_next;
      cell_valid  <= cell_valid_next;
      ring_radius <= ring_radius_next;
      ring_side   <= ring_side_next;
      side_step   <= side_step_next;
      last_radius <= last_radius_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_center_col <= scan_center_col_next;
    scan_center_row <= scan_center_row_next;
    rad_idx         <= rad_idx_next;
    eval_q          <= eval_q_next;
    cell_col        <= cell_col_next;
    cell_row        <= cell_row_next;
    if (accept && opcode == OP_START) begin
      bnd_col_min <= visible_col_min;
      bnd_col_max <= visible_col_max;
      bnd_row_min <= visible_row_min;
      bnd_row_max <= visible_row_max;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIMW'(1);
      grid_height <= DIMW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default:         grid_width  <= grid_width;
      endcase
    end
  end

  always_comb begin
    state_next           = state;
    scan_active_next     = scan_active;
    scan_center_col_next = scan_center_col;
    scan_center_row_next = scan_center_row;
    rad_idx_next         = rad_idx;
    last_radius_next     = last_radius;
    ring_radius_next     = ring_radius;
    ring_side_next       = ring_side;
    side_step_next       = side_step;
    eval_q_next          = eval_q;
    done_next            = 1'b0;
    cell_valid_next      = cell_valid;
    cell_col_next        = cell_col;
    cell_row_next        = cell_row;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_START) begin
            scan_center_col_next = center_col;
            scan_center_row_next = center_row;
            rad_idx_next         = 2'd0;
            state_next           = ST_RADIUS;
          end else if (scan_active) begin
            state_next = ST_SIDE;
          end else begin
            // No scan loaded: answer empty right away
            done_next       = 1'b1;
            cell_valid_next = 1'b0;
            cell_col_next   = '0;
            cell_row_next   = '0;
          end
        end
      end

      ST_RADIUS: begin
        if (rad_idx == 2'd0 || rad_mag > last_radius) begin
          last_radius_next = rad_mag;
        end
        rad_idx_next = rad_idx + 2'd1;
        if (rad_idx == 2'd3) begin
          // Cursor to the centre, acknowledge the start
          ring_radius_next = '0;
          ring_side_next   = SIDE_TOP;
          side_step_next   = '0;
          scan_active_next = 1'b1;
          done_next        = 1'b1;
          cell_valid_next  = 1'b0;
          cell_col_next    = '0;
          cell_row_next    = '0;
          state_next       = ST_IDLE;
        end
      end

      ST_SIDE: begin
        if (ring_radius > last_radius) begin
          // Rings exhausted: drop the scan
          scan_active_next = 1'b0;
          done_next        = 1'b1;
          cell_valid_next  = 1'b0;
          cell_col_next    = '0;
          cell_row_next    = '0;
          state_next       = ST_IDLE;
        end else if (!eval.fixed_ok) begin
          side_step_next   = '0;
          ring_side_next   = side_adv;
          ring_radius_next = ring_adv;
        end else begin
          eval_q_next = eval;
          state_next  = ST_CLIP;
        end
      end

      ST_CLIP: begin
        if (pick.skip) begin
          side_step_next   = '0;
          ring_side_next   = side_adv;
          ring_radius_next = ring_adv;
          state_next       = ST_SIDE;
        end else begin
          done_next       = 1'b1;
          cell_valid_next = 1'b1;
          cell_col_next   = pick.col;
          cell_row_next   = pick.row;
          if (pick.last) begin
            side_step_next   = '0;
            ring_side_next   = side_adv;
            ring_radius_next = ring_adv;
          end else begin
            side_step_next = pick.k_next;
          end
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // A result beat always closes the command, so the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // An empty answer carries zero coordinates
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !cell_valid) |-> (cell_col == '0 && cell_row == '0))
    else $error("empty result with nonzero coordinates");

  // The step cursor never runs past the end of its side
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    scan_active |-> ({1'b0, side_step} <= {1'b0, ring_radius, 1'b0}))
    else $error("side step beyond side length");

  // A start command keeps the unit busy while the radius is worked out
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_START) |=> (busy && !done))
    else $error("start not taken into radius phase");

  // A next command with no loaded scan answers on the following cycle
  a_idle_next: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_NEXT && !scan_active) |=> (done && !cell_valid))
    else $error("next without scan not answered at once");

endmodule
